>>> src/mrpt_pkg.sv
package mrpt_pkg;

  localparam int NUMBER_WIDTH_DEF  = 64;
  localparam int MAX_WITNESSES_DEF = 12;
  localparam int CHOICE_W          = 2;
  localparam int BASE_W            = 6;

  // witness set selector codes
  localparam logic [CHOICE_W-1:0] CHOICE_AUTO  = 2'd0;
  localparam logic [CHOICE_W-1:0] CHOICE_SMALL = 2'd1;
  localparam logic [CHOICE_W-1:0] CHOICE_MID   = 2'd2;
  localparam logic [CHOICE_W-1:0] CHOICE_FULL  = 2'd3;

  localparam int SMALL_COUNT = 3;
  localparam int MID_COUNT   = 9;
  localparam int FULL_COUNT  = 12;

  // magnitude thresholds for automatic set choice
  localparam logic [63:0] SMALL_LIMIT = 64'h0000_0001_0000_0000;
  localparam logic [63:0] MID_LIMIT   = 64'h3400_0000_0000_0000;

  typedef logic [BASE_W-1:0] base_t;

  // base i of the chosen set (small set is 2, 7, 61)
  function automatic base_t base_at(input logic small_set, input logic [3:0] idx);
    base_t b;
    b = '0;
    if (small_set) begin
      case (idx)
        4'd0:    b = 6'd2;
        4'd1:    b = 6'd7;
        default: b = 6'd61;
      endcase
    end else begin
      case (idx)
        4'd0:    b = 6'd2;
        4'd1:    b = 6'd3;
        4'd2:    b = 6'd5;
        4'd3:    b = 6'd7;
        4'd4:    b = 6'd11;
        4'd5:    b = 6'd13;
        4'd6:    b = 6'd17;
        4'd7:    b = 6'd19;
        4'd8:    b = 6'd23;
        4'd9:    b = 6'd29;
        4'd10:   b = 6'd31;
        default: b = 6'd37;
      endcase
    end
    return b;
  endfunction

endpackage

>>> src/miller_rabin_prime_test.sv
// Numbers below 4 and even numbers are answered without any witness test;
//   other numbers run one modular exponentiation and its squarings per witness.
// Throughput: one number at a time; in_tready is low while a test runs.
// The shift-and-add modular multiplier sets the rate.
// Synchronous active-low reset clears control state and sets the witness
// choice register to automatic.
module miller_rabin_prime_test #(
  parameter int NUMBER_WIDTH  = mrpt_pkg::NUMBER_WIDTH_DEF,
  parameter int MAX_WITNESSES = mrpt_pkg::MAX_WITNESSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // [63:0] number
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] is_prime
  input  logic                          cfg_we,
  input  logic [mrpt_pkg::CHOICE_W-1:0] cfg_wdata
);
  import mrpt_pkg::*;

  localparam int W  = NUMBER_WIDTH;
  localparam int SW = $clog2(W + 1);
  localparam int MW = (MAX_WITNESSES < FULL_COUNT) ? MAX_WITNESSES : FULL_COUNT;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SPLIT = 4'd1;
  localparam logic [3:0] ST_BASE  = 4'd2;
  localparam logic [3:0] ST_PSTEP = 4'd3;
  localparam logic [3:0] ST_PMUL  = 4'd4;
  localparam logic [3:0] ST_PSQ   = 4'd5;
  localparam logic [3:0] ST_CHK   = 4'd6;
  localparam logic [3:0] ST_SQ    = 4'd7;
  localparam logic [3:0] ST_SQCHK = 4'd8;
  localparam logic [3:0] ST_MUL   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // where the multiplier returns
  localparam logic [1:0] RET_PMUL = 2'd0;
  localparam logic [1:0] RET_PSQ  = 2'd1;
  localparam logic [1:0] RET_SQ   = 2'd2;

  logic [CHOICE_W-1:0] choice_r;
  logic [3:0]          state_r;
  logic [1:0]          ret_r;
  logic [W-1:0]        n_r, d_r, e_r, acc_r, bse_r;
  logic [SW-1:0]       s_r, k_r;
  logic [3:0]          wi_r, wcnt_r;
  logic                small_r, res_r, out_valid_r;
  logic [W-1:0]        ma_r, mb_r, mr_r;

  logic [W-1:0] nin;
  logic         take, sm, mid;
  logic [W:0]   sum_rb, sum_bb;
  logic [W-1:0] add_rb, add_bb;
  logic [W-1:0] nm1;
  base_t        cur_base;

  assign nin  = in_tdata[W-1:0];
  assign take = in_tvalid && in_tready;
  assign nm1  = n_r - W'(1);

  assign in_tready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r};

  // shared add-mod pair of the doubling multiplier
  assign sum_rb = {1'b0, mr_r} + {1'b0, mb_r};
  assign sum_bb = {1'b0, mb_r} + {1'b0, mb_r};
  assign add_rb = (sum_rb >= {1'b0, n_r}) ? W'(sum_rb - {1'b0, n_r}) : sum_rb[W-1:0];
  assign add_bb = (sum_bb >= {1'b0, n_r}) ? W'(sum_bb - {1'b0, n_r}) : sum_bb[W-1:0];

  // set choice for a new number
  always_comb begin
    sm  = (choice_r == CHOICE_SMALL) ||
          ((choice_r == CHOICE_AUTO) && ({{(64-W){1'b0}}, nin} < SMALL_LIMIT));
    mid = (choice_r == CHOICE_MID) ||
          ((choice_r == CHOICE_AUTO) && ({{(64-W){1'b0}}, nin} < MID_LIMIT));
  end

  assign cur_base = base_at(small_r, wi_r);

  // witness choice register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      choice_r <= CHOICE_AUTO;
    end else if (cfg_we) begin
      choice_r <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (take) begin
            n_r <= nin;
            if (nin <= W'(3)) begin
              res_r       <= (nin >= W'(2));
              out_valid_r <= 1'b1;
            end else if (!nin[0]) begin
              res_r       <= 1'b0;
              out_valid_r <= 1'b1;
            end else begin
              d_r     <= nin - W'(1);
              s_r     <= '0;
              wi_r    <= '0;
              small_r <= sm;
              wcnt_r  <= 4'(sm ? ((SMALL_COUNT < MW) ? SMALL_COUNT : MW)
                              : mid ? ((MID_COUNT < MW) ? MID_COUNT : MW) : MW);
              state_r <= ST_SPLIT;
            end
          end
        end
        // strip factors of two, one per cycle
        ST_SPLIT: begin
          if (d_r[0]) begin
            state_r <= ST_BASE;
          end else begin
            d_r <= d_r >> 1;
            s_r <= s_r + SW'(1);
          end
        end
        ST_BASE: begin
          if (wi_r == wcnt_r) begin
            res_r   <= 1'b1;
            state_r <= ST_DONE;
          end else if ({{(W+1-BASE_W){1'b0}}, cur_base} + (W+1)'(2) > {1'b0, n_r}) begin
            wi_r <= wi_r + 4'd1;
          end else begin
            acc_r   <= W'(1);
            bse_r   <= W'(cur_base);
            e_r     <= d_r;
            state_r <= ST_PSTEP;
          end
        end
        ST_PSTEP: begin
          if (e_r == '0) begin
            state_r <= ST_CHK;
          end else if (e_r[0]) begin
            ma_r <= acc_r; mb_r <= bse_r; mr_r <= '0;
            ret_r <= RET_PMUL; state_r <= ST_MUL;
          end else begin
            state_r <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          e_r <= e_r >> 1;
          if ((e_r >> 1) != '0) begin
            ma_r <= bse_r; mb_r <= bse_r; mr_r <= '0;
            ret_r <= RET_PSQ; state_r <= ST_MUL;
          end else begin
            state_r <= ST_CHK;
          end
        end
        ST_PSQ: state_r <= ST_PSTEP;
        ST_CHK: begin
          k_r <= SW'(1);
          if (acc_r == W'(1) || acc_r == nm1) begin
            wi_r <= wi_r + 4'd1; state_r <= ST_BASE;
          end else begin
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (k_r >= s_r) begin
            res_r <= 1'b0; state_r <= ST_DONE;
          end else begin
            ma_r <= acc_r; mb_r <= acc_r; mr_r <= '0;
            ret_r <= RET_SQ; state_r <= ST_MUL;
          end
        end
        ST_SQCHK: begin
          if (acc_r == W'(1)) begin
            res_r <= 1'b0; state_r <= ST_DONE;
          end else if (acc_r == nm1) begin
            wi_r <= wi_r + 4'd1; state_r <= ST_BASE;
          end else begin
            k_r <= k_r + SW'(1); state_r <= ST_SQ;
          end
        end
        // one doubling step per cycle
        ST_MUL: begin
          if (ma_r == '0) begin
            case (ret_r)
              RET_PMUL: begin acc_r <= mr_r; state_r <= ST_PMUL; end
              RET_PSQ:  begin bse_r <= mr_r; state_r <= ST_PSQ; end
              default:  begin acc_r <= mr_r; state_r <= ST_SQCHK; end
            endcase
          end else begin
            if (ma_r[0]) mr_r <= add_rb;
            mb_r <= add_bb;
            ma_r <= ma_r >> 1;
          end
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result only leaves while the sequencer is parked
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE)) else $error("result while busy");
  // no request taken while a result waits
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_tready) else $error("ready with pending result");
  // the doubled multiplier operand mb_r stays reduced
  a_mb_red: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (mb_r < n_r)) else $error("operand not reduced");
endmodule

>>> bench/miller_rabin_prime_test_tb.sv
`timescale 1ns / 1ps

module miller_rabin_prime_test_tb;
  import mrpt_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [63:0]         in_tdata;   // [63:0] number
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [0] is_prime
  logic                cfg_we;
  logic [CHOICE_W-1:0] cfg_wdata;

  logic                verdict_q[$];
  logic [63:0]         number_q[$];
  logic [CHOICE_W-1:0] choice_mirror;
  int                  errors;
  int                  send_idle_pct;
  int                  sink_stall_pct;
  int                  hold_cycles;

  miller_rabin_prime_test dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // (x + y) mod m with the carry kept
  function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] r;
    r = '0;
    b = b % m;
    while (a != 0) begin
      if (a[0]) r = add_mod(r, b, m);
      a = a >> 1;
      b = add_mod(b, b, m);
    end
    return r;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] g, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    g = g % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, g, m);
      e = e >> 1;
      if (e != 0) g = mul_mod(g, g, m);
    end
    return acc;
  endfunction

  // expected primality verdict under the given witness set choice
  function automatic logic prime_verdict(logic [63:0] n, logic [CHOICE_W-1:0] choice);
    int          bases[12];
    int          count;
    int          s;
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] a;
    logic        composite;
    if (n <= 1) return 1'b0;
    if (n <= 3) return 1'b1;
    if (!n[0]) return 1'b0;
    bases = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    if (choice == CHOICE_SMALL || (choice == CHOICE_AUTO && n < SMALL_LIMIT)) begin
      bases[1] = 7;
      bases[2] = 61;
      count = SMALL_COUNT;
    end else if (choice == CHOICE_MID || (choice == CHOICE_AUTO && n < MID_LIMIT)) begin
      count = MID_COUNT;
    end else begin
      count = FULL_COUNT;
    end
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < count; i++) begin
      a = 64'(bases[i]);
      if (a + 2 > n) continue;
      x = pow_mod(a, d, n);
      if (x == 1 || x == n - 1) continue;
      composite = 1'b1;
      for (int k = 1; k < s; k++) begin
        x = mul_mod(x, x, n);
        if (x == 1) return 1'b0;
        if (x == n - 1) begin
          composite = 1'b0;
          break;
        end
      end
      if (composite) return 1'b0;
    end
    return 1'b1;
  endfunction

  // offer one request, holding it until the block takes it
  task automatic send_number(input logic [63:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= n;
    do @(posedge clk); while (!in_tready);
    verdict_q.push_back(prime_verdict(n, choice_mirror));
    number_q.push_back(n);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write the choice register while the block is idle
  task automatic set_choice(input logic [CHOICE_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    choice_mirror = v;
  endtask

  // mostly small odd numbers so that tests stay short
  function automatic logic [63:0] rand_number();
    int r;
    int w;
    r = $urandom_range(99);
    w = $urandom_range(20, 2);
    if (r < 8) return {$urandom, $urandom};
    if (r < 20) return {$urandom, $urandom} & ~64'd1;
    return (64'($urandom) & ((64'd1 << w) - 1)) | 64'd1;
  endfunction

  task automatic test_directed;
    logic [63:0] vals[$];
    vals = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd9, 64'd25, 64'd61,
             64'd63, 64'd3215031751, 64'd4294967291, 64'd4294967295,
             64'h8000_0000_0000_0000, 64'd2305843009213693951,
             64'd3825123056546413051, 64'd18446744073709551557,
             64'hFFFF_FFFF_FFFF_FFFF};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  // forced sets, including a pseudoprime the mid set cannot catch
  task automatic test_forced_sets;
    logic [63:0] vals[$];
    vals = '{64'd5, 64'd61, 64'd3215031751, 64'd3825123056546413051, 64'd1000003};
    for (int c = CHOICE_SMALL; c <= CHOICE_FULL; c++) begin
      set_choice(CHOICE_W'(c));
      foreach (vals[i]) send_number(vals[i]);
    end
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    send_idle_pct  = idle;
    sink_stall_pct = stall;
    repeat (count) send_number(rand_number());
  endtask

  // receiver holds off long while requests keep coming
  task automatic test_backpressure;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_cycles    = 2000;
    repeat (4) send_number(64'($urandom_range(200)));
  endtask

  // check each result against the oldest expectation, and pace out_tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual is_prime %0b",
                 $realtime, out_tdata[0]);
        errors++;
      end else begin
        if (out_tdata[0] !== verdict_q[0]) begin
          $display("%0t: number %0d: expected is_prime %0b, actual %0b",
                   $realtime, number_q[0], verdict_q[0], out_tdata[0]);
          errors++;
        end
        void'(verdict_q.pop_front());
        void'(number_q.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = CHOICE_AUTO;
    choice_mirror  = CHOICE_AUTO;
    errors         = 0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_cycles    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_forced_sets();
    set_choice(CHOICE_AUTO);
    test_random(15, 0, 0);
    test_random(15, 82, 0);
    test_backpressure();
    set_choice(CHOICE_MID);
    test_random(15, 0, 82);
    set_choice(CHOICE_AUTO);
    test_random(15, 23, 23);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
src/mrpt_pkg.sv
src/miller_rabin_prime_test.sv
bench/miller_rabin_prime_test_tb.sv
